### hw/rtl/ite_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ite_pkg
// Shared types, constants and tables of the tilt and yaw estimator.
// ---------------------------------------------------------------------------
package ite_pkg;

   localparam int CORDIC_STEPS        = 16;
   localparam int ANGLE_FRACTION_BITS = 7;
   localparam int TABLE_LEN           = 24;
   localparam int STEP_INDEX_WIDTH    = $clog2(TABLE_LEN);
   localparam int VEC_WIDTH           = 34;
   localparam int ANG_WIDTH           = 26;
   localparam int PRESCALE_SHIFT      = 14;

   localparam logic signed [ANG_WIDTH-1:0] HALF_TURN = ANG_WIDTH'(180 * 65536);
   localparam logic signed [ANG_WIDTH-1:0] ROLL_LIMIT =
      ANG_WIDTH'(180 * (1 << ANGLE_FRACTION_BITS));
   localparam logic signed [ANG_WIDTH-1:0] PITCH_LIMIT =
      ANG_WIDTH'(90 * (1 << ANGLE_FRACTION_BITS));

   localparam logic REG_YAW_STEP_GAIN = 1'b0;
   localparam logic REG_BLEND_WEIGHT  = 1'b1;

   typedef struct packed {
      logic                        valid;
      logic                        pitch;
      logic                        zero;
      logic signed [VEC_WIDTH-1:0] x;
      logic signed [VEC_WIDTH-1:0] y;
      logic signed [ANG_WIDTH-1:0] z;
   } cell_type;

   // atan(2^-i) in degrees, Q16
   function automatic logic signed [ANG_WIDTH-1:0] atan_entry(
      input logic [STEP_INDEX_WIDTH-1:0] idx);
      logic [21:0] v;
      case (idx)
         5'd0:  v = 22'd2949120;
         5'd1:  v = 22'd1740967;
         5'd2:  v = 22'd919879;
         5'd3:  v = 22'd466945;
         5'd4:  v = 22'd234379;
         5'd5:  v = 22'd117304;
         5'd6:  v = 22'd58666;
         5'd7:  v = 22'd29335;
         5'd8:  v = 22'd14668;
         5'd9:  v = 22'd7334;
         5'd10: v = 22'd3667;
         5'd11: v = 22'd1833;
         5'd12: v = 22'd917;
         5'd13: v = 22'd458;
         5'd14: v = 22'd229;
         5'd15: v = 22'd115;
         5'd16: v = 22'd57;
         5'd17: v = 22'd29;
         5'd18: v = 22'd14;
         5'd19: v = 22'd7;
         5'd20: v = 22'd4;
         5'd21: v = 22'd2;
         5'd22: v = 22'd1;
         default: v = 22'd0;
      endcase
      return $signed({4'b0000, v});
   endfunction

   // Half-plane fold and prescale of an atan2(y, x) operand pair
   function automatic cell_type cordic_load(
      input logic signed [16:0] y,
      input logic signed [16:0] x,
      input logic               pitch);
      cell_type c;
      logic signed [VEC_WIDTH-1:0] xe;
      logic signed [VEC_WIDTH-1:0] ye;
      xe = VEC_WIDTH'(x);
      ye = VEC_WIDTH'(y);
      c.valid = 1'b1;
      c.pitch = pitch;
      c.zero  = (x == 17'sd0) && (y == 17'sd0);
      c.z     = '0;
      if (x < 17'sd0) begin
         c.z = (y >= 17'sd0) ? HALF_TURN : -HALF_TURN;
         xe  = -xe;
         ye  = -ye;
      end
      c.x = xe <<< PRESCALE_SHIFT;
      c.y = ye <<< PRESCALE_SHIFT;
      return c;
   endfunction

endpackage

### hw/rtl/ite_cordic_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ite_cordic_cell
// One vectoring CORDIC rotation with a fixed shift, registered.
// ---------------------------------------------------------------------------
module ite_cordic_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [ite_pkg::STEP_INDEX_WIDTH-1:0] step_index,
   input  ite_pkg::cell_type                    link_in,
   output ite_pkg::cell_type                    link_out
);
   import ite_pkg::*;

   cell_type link_in_c;
   cell_type link_ff;
   logic signed [VEC_WIDTH-1:0] dx;
   logic signed [VEC_WIDTH-1:0] dy;

   always_comb begin
      dx        = link_in.y >>> step_index;
      dy        = link_in.x >>> step_index;
      link_in_c = link_in;
      if (link_in.y >= 0) begin
         link_in_c.x = link_in.x + dx;
         link_in_c.y = link_in.y - dy;
         link_in_c.z = link_in.z + atan_entry(step_index);
      end else begin
         link_in_c.x = link_in.x - dx;
         link_in_c.y = link_in.y + dy;
         link_in_c.z = link_in.z - atan_entry(step_index);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else begin
         link_ff <= link_in_c;
      end
   end

   assign link_out = link_ff;

endmodule

### hw/rtl/ite_isqrt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ite_isqrt
// Integer square root of a 32-bit value, two radicand bits per cycle.
// ---------------------------------------------------------------------------
module ite_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] value,
   output logic        done,
   output logic [15:0] root
);
   import ite_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [3:0]  step_ff, step_in;
   logic [31:0] n_ff, n_in;
   logic [31:0] root_ff, root_in;
   logic [31:0] bit_w;
   logic [32:0] trial;

   always_comb begin
      bit_w   = 32'h4000_0000 >> {step_ff, 1'b0};
      trial   = {1'b0, root_ff} + {1'b0, bit_w};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      n_in    = n_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         n_in    = value;
         root_in = '0;
      end else if (busy_ff) begin
         if ({1'b0, n_ff} >= trial) begin
            n_in    = n_ff - trial[31:0];
            root_in = (root_ff >> 1) + bit_w;
         end else begin
            root_in = root_ff >> 1;
         end
         step_in = step_ff + 4'd1;
         if (step_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      n_ff    <= n_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff[15:0];

endmodule

### hw/rtl/imu_tilt_and_yaw_estimator_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imu_tilt_and_yaw_estimator_unit
// Roll, pitch and blended yaw from one accelerometer triple and gyro z.
// ---------------------------------------------------------------------------
// One item at a time. Roll enters the row of CORDIC cells on the accepting
// edge; pitch waits for the square root of ay^2+az^2 and then runs the same
// row, so the root plus the cell row set the item time. A finished result
// sits in the output register while the next item is taken in.
module imu_tilt_and_yaw_estimator_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_gyro_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_roll_angle,
   output logic signed [14:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_yaw_angle,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [16:0]        csr_data
);
   import ite_pkg::*;

   typedef enum logic [2:0] {IDLE, SQUARE, ROOT, PITCH_WAIT, FINISH} state_type;

   state_type state_ff, state_in;
   logic [1:0]  yaw_step_ff, yaw_step_in;
   logic [15:0] gain_ff;
   logic [16:0] weight_ff;
   logic signed [15:0] ax_ff, ay_ff, az_ff, gz_ff;
   logic signed [32:0] prod_ff, prod_in;
   logic signed [39:0] acc_ff, acc_in;
   logic signed [15:0] prev_ff, prev_in;
   logic signed [33:0] m1_ff, m1_in;
   logic signed [41:0] m2_ff, m2_in;
   logic signed [15:0] yaw_ff, yaw_in;
   logic signed [15:0] roll_ff, roll_in;
   logic signed [14:0] pitch_ff, pitch_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_roll_ff, rsp_roll_in;
   logic signed [14:0] rsp_pitch_ff, rsp_pitch_in;
   logic signed [15:0] rsp_yaw_ff, rsp_yaw_in;

   logic        accept;
   logic [31:0] square_sum;
   logic        root_done;
   logic [15:0] root_value;
   logic signed [40:0] acc_sum;
   logic [16:0] w_eff;
   logic [16:0] w_comp;
   logic signed [42:0] blend_sum;
   logic signed [26:0] blend_q;
   logic signed [ANG_WIDTH-1:0] angle_r;
   cell_type link [0:CORDIC_STEPS];
   cell_type tail;

   function automatic logic signed [ANG_WIDTH-1:0] round_angle(
      input cell_type c, input logic signed [ANG_WIDTH-1:0] lim);
      logic signed [ANG_WIDTH-1:0] r;
      r = (c.z + (ANG_WIDTH'(1) <<< (15 - ANGLE_FRACTION_BITS)))
          >>> (16 - ANGLE_FRACTION_BITS);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      if (c.zero) r = '0;
      return r;
   endfunction

   assign accept     = req_valid && req_ready;
   assign req_ready  = (state_ff == IDLE);
   assign square_sum = 32'($signed(ay_ff) * $signed(ay_ff))
                     + 32'($signed(az_ff) * $signed(az_ff));

   ite_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (state_ff == SQUARE),
      .value (square_sum),
      .done  (root_done),
      .root  (root_value)
   );

   always_comb begin
      link[0] = '0;
      if (accept) begin
         link[0] = cordic_load(17'(req_accel_y), 17'(req_accel_z), 1'b0);
      end else if (state_ff == ROOT && root_done) begin
         link[0] = cordic_load(-17'(ax_ff), {1'b0, root_value}, 1'b1);
      end
   end

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
      ite_cordic_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .step_index (STEP_INDEX_WIDTH'(g)),
         .link_in    (link[g]),
         .link_out   (link[g+1])
      );
   end

   assign tail = link[CORDIC_STEPS];

   always_comb begin
      state_in     = state_ff;
      yaw_step_in  = yaw_step_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      prev_in      = prev_ff;
      m1_in        = m1_ff;
      m2_in        = m2_ff;
      yaw_in       = yaw_ff;
      roll_in      = roll_ff;
      pitch_in     = pitch_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_roll_in  = rsp_roll_ff;
      rsp_pitch_in = rsp_pitch_ff;
      rsp_yaw_in   = rsp_yaw_ff;

      acc_sum   = 41'(acc_ff) + 41'(prod_ff);
      w_eff     = (weight_ff > 17'h10000) ? 17'h10000 : weight_ff;
      w_comp    = 17'h10000 - w_eff;
      blend_sum = 43'(m1_ff) + 43'(m2_ff) + 43'sd32768;
      blend_q   = blend_sum[42:16];
      angle_r   = round_angle(tail, tail.pitch ? PITCH_LIMIT : ROLL_LIMIT);

      if (tail.valid && !tail.pitch) roll_in = angle_r[15:0];

      unique case (state_ff)
         IDLE: begin
            if (accept) state_in = SQUARE;
         end
         SQUARE: begin
            prod_in     = 33'($signed(gz_ff) * $signed({1'b0, gain_ff}));
            yaw_step_in = '0;
            state_in    = ROOT;
         end
         ROOT: begin
            if (yaw_step_ff != 2'd3) yaw_step_in = yaw_step_ff + 2'd1;
            case (yaw_step_ff)
               2'd0: begin
                  if (acc_sum > 41'sh7F_FFFF_FFFF)       acc_in = 40'sh7F_FFFF_FFFF;
                  else if (acc_sum < -41'sh80_0000_0000) acc_in = 40'sh80_0000_0000;
                  else                                   acc_in = acc_sum[39:0];
               end
               2'd1: begin
                  m1_in = 34'(prev_ff * $signed({1'b0, w_comp}));
                  m2_in = 42'($signed(acc_ff[39:16]) * $signed({1'b0, w_eff}));
               end
               2'd2: begin
                  if (blend_q > 27'sd32767)       yaw_in = 16'sh7FFF;
                  else if (blend_q < -27'sd32768) yaw_in = 16'sh8000;
                  else                            yaw_in = blend_q[15:0];
                  prev_in = yaw_in;
               end
               default: ;
            endcase
            if (root_done) state_in = PITCH_WAIT;
         end
         PITCH_WAIT: begin
            if (tail.valid && tail.pitch) begin
               pitch_in = angle_r[14:0];
               state_in = FINISH;
            end
         end
         FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_roll_in  = roll_ff;
               rsp_pitch_in = pitch_ff;
               rsp_yaw_in   = yaw_ff;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         yaw_step_ff  <= '0;
         gain_ff      <= 16'd640;
         weight_ff    <= 17'd1311;
         acc_ff       <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         yaw_step_ff  <= yaw_step_in;
         acc_ff       <= acc_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               REG_YAW_STEP_GAIN: gain_ff   <= csr_data[15:0];
               REG_BLEND_WEIGHT:  weight_ff <= csr_data;
               default: ;
            endcase
         end
      end
      if (accept) begin
         ax_ff <= req_accel_x;
         ay_ff <= req_accel_y;
         az_ff <= req_accel_z;
         gz_ff <= req_gyro_z;
      end
      prod_ff      <= prod_in;
      m1_ff        <= m1_in;
      m2_ff        <= m2_in;
      yaw_ff       <= yaw_in;
      roll_ff      <= roll_in;
      pitch_ff     <= pitch_in;
      rsp_roll_ff  <= rsp_roll_in;
      rsp_pitch_ff <= rsp_pitch_in;
      rsp_yaw_ff   <= rsp_yaw_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_roll_angle  = rsp_roll_ff;
   assign rsp_pitch_angle = rsp_pitch_ff;
   assign rsp_yaw_angle   = rsp_yaw_ff;

`ifndef SYNTHESIS
   a_accept_to_square: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == SQUARE)
      else $error("transfer did not start square stage");
   a_root_only_in_root: assert property (@(posedge clock) disable iff (reset)
      root_done |-> state_ff == ROOT)
      else $error("square root finished outside root stage");
   a_pitch_tail_waits: assert property (@(posedge clock) disable iff (reset)
      (tail.valid && tail.pitch) |-> state_ff == PITCH_WAIT)
      else $error("pitch left cell row unexpectedly");
   a_single_inject: assert property (@(posedge clock) disable iff (reset)
      link[0].valid |=> !link[0].valid)
      else $error("cell row loaded on consecutive cycles");
`endif

endmodule
